[src/longest_common_substring_top_defines.svh]
// assertion macros for the longest common substring block
`ifndef LONGEST_COMMON_SUBSTRING_TOP_DEFINES_SVH
`define LONGEST_COMMON_SUBSTRING_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define LCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define LCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LCS_ASSERT_IMP(lbl, ante, cons, msg)

`define LCS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[src/lcs_pkg.sv]
// shared types and constants for the longest common substring block
package lcs_pkg;

  localparam int SYM_W = 8;
  localparam int RUN_W = 7;
  localparam logic [RUN_W-1:0] RUN_MAX = 7'd127;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } lcs_op_t;

  // request travelling along the row of cells
  typedef struct packed {
    logic             valid;
    lcs_op_t          op;
    logic [SYM_W-1:0] sym;
    logic             last;
    logic             wr;
    logic [RUN_W-1:0] diag;
    logic [RUN_W-1:0] best;
  } lcs_tok_t;

endpackage

[src/lcs_in_if.sv]
// input channel carrying operation, symbol and last flag
interface lcs_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output operation, output symbol, output last, input ready);
  modport sink (input valid, input operation, input symbol, input last, output ready);
endinterface

[src/lcs_out_if.sv]
// result channel carrying the longest common substring length
interface lcs_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] longest_length;

  modport source (output valid, output longest_length, input ready);
  modport sink (input valid, input longest_length, output ready);
endinterface

[src/lcs_head.sv]
// input stage: reference length tracking and request forming
`include "longest_common_substring_top_defines.svh"

module lcs_head
  import lcs_pkg::*;
#(
  parameter int MAX_LEN = 64,
  localparam int CW = $clog2(MAX_LEN + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  lcs_in_if.sink        in_chan,
  output lcs_tok_t      tok_o,
  output logic [CW-1:0] cnt_o
);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] base;
  logic          room;
  logic          acc;
  lcs_op_t       op;

  assign in_chan.ready = adv;
  assign acc  = in_chan.valid && adv;
  assign op   = lcs_op_t'(in_chan.operation);
  assign base = done_r ? '0 : cnt_r;
  assign room = base < CW'(MAX_LEN);

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = done_r;
    if (acc && op == OP_LOAD) begin
      cnt_nxt  = room ? base + CW'(1) : base;
      done_nxt = in_chan.last;
    end
  end

  always_comb begin
    tok_o.valid = acc;
    tok_o.op    = op;
    tok_o.sym   = in_chan.symbol;
    tok_o.last  = in_chan.last;
    tok_o.wr    = (op == OP_LOAD) && room;
    tok_o.diag  = '0;
    tok_o.best  = '0;
    cnt_o       = (op == OP_LOAD) ? base : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  `LCS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CW'(MAX_LEN), "reference count above capacity")
  `LCS_ASSERT_NXT(a_load_counts, acc && op == OP_LOAD, cnt_r != '0,
                  "reference count empty after a load")
  `LCS_ASSERT_NXT(a_last_ends_ref, acc && op == OP_LOAD && in_chan.last, done_r,
                  "reference not closed by its last symbol")

endmodule

[src/lcs_cell.sv]
// one reference position: stored symbol and run length ending here
module lcs_cell
  import lcs_pkg::*;
#(
  parameter int MAX_LEN = 64,
  parameter int IDX = 0,
  localparam int CW = $clog2(MAX_LEN + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  lcs_tok_t      tok_i,
  input  logic [CW-1:0] cnt_i,
  output lcs_tok_t      tok_o,
  output logic [CW-1:0] cnt_o
);

  logic [SYM_W-1:0] sym_r;
  logic [RUN_W-1:0] run_r, run_nxt;
  lcs_tok_t         tok_r, tok_nxt;
  logic [CW-1:0]    cnt_r;
  logic             is_query, is_load, active, hit;
  logic [RUN_W-1:0] run_v;

  assign is_query = tok_i.valid && tok_i.op == OP_QUERY;
  assign is_load  = tok_i.valid && tok_i.op == OP_LOAD;
  assign active   = CW'(IDX) < cnt_i;
  assign hit      = is_query && active && (sym_r == tok_i.sym);

  always_comb begin
    run_v = '0;
    if (hit) begin
      run_v = (tok_i.diag == RUN_MAX) ? RUN_MAX : tok_i.diag + RUN_W'(1);
    end
  end

  always_comb begin
    run_nxt = run_r;
    if (is_query) begin
      run_nxt = tok_i.last ? '0 : (active ? run_v : run_r);
    end else if (is_load && tok_i.last) begin
      run_nxt = '0;
    end
    tok_nxt      = tok_i;
    tok_nxt.diag = run_r;
    tok_nxt.best = (run_v > tok_i.best) ? run_v : tok_i.best;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
      tok_r <= '0;
    end else if (adv) begin
      run_r <= run_nxt;
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cnt_r <= cnt_i;
      if (is_load && tok_i.wr && cnt_i == CW'(IDX)) begin
        sym_r <= tok_i.sym;
      end
    end
  end

  assign tok_o = tok_r;
  assign cnt_o = cnt_r;

endmodule

[src/lcs_tail.sv]
// end of the row: best length tracking and result register
module lcs_tail
  import lcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  lcs_tok_t tok_i,
  output logic     adv,
  lcs_out_if.source out_chan
);

  logic [RUN_W-1:0] best_r, best_nxt;
  logic [RUN_W-1:0] len_r, len_nxt;
  logic             oval_r, oval_nxt;
  logic             is_query, stall;
  logic [RUN_W-1:0] merged;

  assign is_query = tok_i.valid && tok_i.op == OP_QUERY;
  assign stall    = is_query && tok_i.last && oval_r && !out_chan.ready;
  assign adv      = !stall;
  assign merged   = (tok_i.best > best_r) ? tok_i.best : best_r;

  always_comb begin
    best_nxt = best_r;
    len_nxt  = len_r;
    oval_nxt = oval_r && !out_chan.ready;
    if (adv && tok_i.valid) begin
      if (is_query) begin
        if (tok_i.last) begin
          len_nxt  = merged;
          oval_nxt = 1'b1;
          best_nxt = '0;
        end else begin
          best_nxt = merged;
        end
      end else if (tok_i.last) begin
        best_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
      oval_r <= 1'b0;
    end else begin
      best_r <= best_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
  end

  assign out_chan.valid          = oval_r;
  assign out_chan.longest_length = len_r;

endmodule

[src/longest_common_substring_top.sv]
// longest common substring length finder, top level
// Reference bytes load into a row of MAX_LEN cells, one byte per cell; query bytes then
// flow along the row one cell per cycle unless the row stalls, each cell adding one to
// the run handed over by its left neighbour on a match, with the best run carried along
// beside the byte. One item of either kind is taken every cycle unless the row stalls; a
// query's length passes through the cell registers into the tail's result register.
// The input stalls only while a finished length waits at the output and the next one
// reaches the end of the row. A new reference may follow queries immediately.
`include "longest_common_substring_top_defines.svh"

module longest_common_substring_top
  import lcs_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  lcs_in_if.sink     in_chan,
  lcs_out_if.source  out_chan
);

  localparam int CW = $clog2(MAX_LEN + 1);

  lcs_tok_t      tok [MAX_LEN+1];
  logic [CW-1:0] cnt [MAX_LEN+1];
  logic          adv;

  lcs_head #(.MAX_LEN(MAX_LEN)) u_head (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_chan (in_chan),
    .tok_o   (tok[0]),
    .cnt_o   (cnt[0])
  );

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    lcs_cell #(.MAX_LEN(MAX_LEN), .IDX(j)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tok_i (tok[j]),
      .cnt_i (cnt[j]),
      .tok_o (tok[j+1]),
      .cnt_o (cnt[j+1])
    );
  end

  lcs_tail u_tail (
    .clk      (clk),
    .rst_n    (rst_n),
    .tok_i    (tok[MAX_LEN]),
    .adv      (adv),
    .out_chan (out_chan)
  );

  `LCS_ASSERT_IMP(a_stall_cause, !adv, out_chan.valid && !out_chan.ready,
                  "row stalled without a pending result")

endmodule
